@@ hdl/pge_pkg.sv @@
// ----------------------------------------------------------------------------
// Polygon edge overlap package
// Shared payload types, vertex type, operation codes and arithmetic widths.
// ----------------------------------------------------------------------------
`default_nettype none

package pge_pkg;

    localparam int IN_COORD_W = 16;
    localparam int DIFF_W     = IN_COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int EDGE_W     = 4;

    localparam logic [1:0] OP_ADD_FIRST  = 2'd0;
    localparam logic [1:0] OP_ADD_SECOND = 2'd1;
    localparam logic [1:0] OP_TEST       = 2'd2;

    typedef struct packed {
        logic [1:0]                   operation;
        logic signed [IN_COORD_W-1:0] x_coord;
        logic signed [IN_COORD_W-1:0] y_coord;
    } pge_in_t;

    typedef struct packed {
        logic              overlap;
        logic [EDGE_W-1:0] edge_first;
        logic [EDGE_W-1:0] edge_second;
    } pge_out_t;

    typedef struct packed {
        logic signed [IN_COORD_W-1:0] x;
        logic signed [IN_COORD_W-1:0] y;
    } vertex_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic last;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/pge_cell.sv @@
// ----------------------------------------------------------------------------
// Vertex cell
// Holds one polygon vertex; loads a new vertex or takes its neighbor's vertex.
// ----------------------------------------------------------------------------
`default_nettype none

module pge_cell (
    input  wire logic                clk,
    input  wire pge_pkg::cell_ctrl_t ctrl,
    input  wire pge_pkg::vertex_t    load_vtx,
    input  wire pge_pkg::vertex_t    nbr_vtx,
    input  wire pge_pkg::vertex_t    wrap_vtx,
    output pge_pkg::vertex_t         vtx
);
    import pge_pkg::*;

    vertex_t vtx_reg;

    // The last occupied cell takes the head vertex so the ring closes at the count.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            vtx_reg <= load_vtx;
        end
        else if (ctrl.shift)
        begin
            vtx_reg <= ctrl.last ? wrap_vtx : nbr_vtx;
        end
    end

    assign vtx = vtx_reg;

endmodule

`default_nettype wire

@@ hdl/pge_pair_unit.sv @@
// ----------------------------------------------------------------------------
// Edge pair unit
// Three-stage pipeline deciding whether segment a-b meets segment c-d.
// ----------------------------------------------------------------------------
`default_nettype none

module pge_pair_unit #(
    parameter int TAG_W = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             flush,
    input  wire logic             in_vld,
    input  wire pge_pkg::vertex_t a,
    input  wire pge_pkg::vertex_t b,
    input  wire pge_pkg::vertex_t c,
    input  wire pge_pkg::vertex_t d,
    input  wire logic [TAG_W-1:0] in_tag,
    output logic                  res_vld,
    output logic                  res_hit,
    output logic [TAG_W-1:0]      res_tag
);
    import pge_pkg::*;

    logic                     v1_reg, v2_reg, v3_reg;
    logic [TAG_W-1:0]         t1_reg, t2_reg, t3_reg;
    logic signed [DIFF_W-1:0] abx_reg, aby_reg, cdx_reg, cdy_reg, acx_reg, acy_reg;
    logic signed [PROD_W-1:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    logic                     hit_reg;
    logic signed [SUM_W-1:0]  den, na, nb;
    logic                     hit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (flush)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg  <= in_tag;
        abx_reg <= DIFF_W'(b.x) - DIFF_W'(a.x);
        aby_reg <= DIFF_W'(b.y) - DIFF_W'(a.y);
        cdx_reg <= DIFF_W'(d.x) - DIFF_W'(c.x);
        cdy_reg <= DIFF_W'(d.y) - DIFF_W'(c.y);
        acx_reg <= DIFF_W'(a.x) - DIFF_W'(c.x);
        acy_reg <= DIFF_W'(a.y) - DIFF_W'(c.y);

        t2_reg <= t1_reg;
        p1_reg <= PROD_W'(cdy_reg) * PROD_W'(abx_reg);
        p2_reg <= PROD_W'(cdx_reg) * PROD_W'(aby_reg);
        p3_reg <= PROD_W'(cdx_reg) * PROD_W'(acy_reg);
        p4_reg <= PROD_W'(cdy_reg) * PROD_W'(acx_reg);
        p5_reg <= PROD_W'(abx_reg) * PROD_W'(acy_reg);
        p6_reg <= PROD_W'(aby_reg) * PROD_W'(acx_reg);

        t3_reg  <= t2_reg;
        hit_reg <= hit_next;
    end

    always_comb
    begin
        den = SUM_W'(p1_reg) - SUM_W'(p2_reg);
        na  = SUM_W'(p3_reg) - SUM_W'(p4_reg);
        nb  = SUM_W'(p5_reg) - SUM_W'(p6_reg);
        if (den == '0)
        begin
            hit_next = 1'b0;
        end
        else if (den > 0)
        begin
            hit_next = (na >= 0) && (na <= den) && (nb >= 0) && (nb <= den);
        end
        else
        begin
            hit_next = (na <= 0) && (na >= den) && (nb <= 0) && (nb >= den);
        end
    end

    assign res_vld = v3_reg;
    assign res_hit = hit_reg;
    assign res_tag = t3_reg;

endmodule

`default_nettype wire

@@ hdl/polygon_edge_overlap_test.sv @@
// ----------------------------------------------------------------------------
// Polygon edge overlap test
// Loads two polygons into rings of vertex cells and tests all edge pairs.
// ----------------------------------------------------------------------------
// A test walks the edge pairs in order, first polygon outer and second inner,
// one pair per cycle through a three-stage cross-product pipeline. The result
// comes from the first pair that hits, or else from the last pair; the rotation
// of the two vertex rings sets the pair order. A test with an empty polygon
// answers without entering the pipeline. Both stores are empty after each test.
// Loads are still taken while a result waits to be transferred.
`default_nettype none

module polygon_edge_overlap_test #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_BITS   = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire pge_pkg::pge_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output pge_pkg::pge_out_t     out_data
);
    import pge_pkg::*;

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int TAG_W = 2 * IDX_W + 1;
    localparam int SH    = (COORD_BITS < IN_COORD_W) ? IN_COORD_W - COORD_BITS : 0;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] fcnt_reg, fcnt_next, scnt_reg, scnt_next;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next;
    logic             out_valid_reg, out_valid_next;
    pge_out_t         out_data_reg, out_data_next;

    logic             accept, start_run, issue, wrap_j, wrap_i, finish, flush;
    logic             shift_f, shift_s;
    vertex_t          load_vtx;
    logic signed [IN_COORD_W-1:0] x_sh, y_sh;

    vertex_t          fv [MAX_VERTICES];
    vertex_t          sv [MAX_VERTICES];
    cell_ctrl_t       fctl [MAX_VERTICES];
    cell_ctrl_t       sctl [MAX_VERTICES];

    vertex_t          f_next_vtx, s_next_vtx;
    logic             res_vld, res_hit;
    logic [TAG_W-1:0] res_tag;
    logic [IDX_W-1:0] res_i, res_j;

    // Coordinates wrap to the configured width as two's complement.
    assign x_sh     = in_data.x_coord <<< SH;
    assign y_sh     = in_data.y_coord <<< SH;
    assign load_vtx = '{x: x_sh >>> SH, y: y_sh >>> SH};

    assign in_ready = (state_reg == ST_IDLE) &&
                      (!out_valid_reg || (in_data.operation != OP_TEST));
    assign accept   = in_valid && in_ready;

    assign issue   = (state_reg == ST_RUN);
    assign wrap_j  = (CNT_W'(j_reg) == scnt_reg - CNT_W'(1));
    assign wrap_i  = (CNT_W'(i_reg) == fcnt_reg - CNT_W'(1));
    assign shift_s = issue;
    assign shift_f = issue && wrap_j;

    genvar k;
    generate
        for (k = 0; k < MAX_VERTICES; k++)
        begin : g_cells
            always_comb
            begin
                fctl[k].load  = accept && (in_data.operation == OP_ADD_FIRST) &&
                                (fcnt_reg == CNT_W'(k));
                fctl[k].shift = shift_f;
                fctl[k].last  = (fcnt_reg == CNT_W'(k + 1));
                sctl[k].load  = accept && (in_data.operation == OP_ADD_SECOND) &&
                                (scnt_reg == CNT_W'(k));
                sctl[k].shift = shift_s;
                sctl[k].last  = (scnt_reg == CNT_W'(k + 1));
            end

            pge_cell u_fcell (
                .clk      (clk),
                .ctrl     (fctl[k]),
                .load_vtx (load_vtx),
                .nbr_vtx  (fv[(k + 1) % MAX_VERTICES]),
                .wrap_vtx (fv[0]),
                .vtx      (fv[k])
            );

            pge_cell u_scell (
                .clk      (clk),
                .ctrl     (sctl[k]),
                .load_vtx (load_vtx),
                .nbr_vtx  (sv[(k + 1) % MAX_VERTICES]),
                .wrap_vtx (sv[0]),
                .vtx      (sv[k])
            );
        end
    endgenerate

    // A one-vertex polygon has a single degenerate edge from vertex 0 to itself.
    assign f_next_vtx = (fcnt_reg > CNT_W'(1)) ? fv[1] : fv[0];
    assign s_next_vtx = (scnt_reg > CNT_W'(1)) ? sv[1] : sv[0];

    pge_pair_unit #(
        .TAG_W (TAG_W)
    ) u_pair (
        .clk     (clk),
        .rst_n   (rst_n),
        .flush   (flush),
        .in_vld  (issue),
        .a       (fv[0]),
        .b       (f_next_vtx),
        .c       (sv[0]),
        .d       (s_next_vtx),
        .in_tag  ({wrap_j && wrap_i, i_reg, j_reg}),
        .res_vld (res_vld),
        .res_hit (res_hit),
        .res_tag (res_tag)
    );

    assign res_i = res_tag[2*IDX_W-1:IDX_W];
    assign res_j = res_tag[IDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        fcnt_next      = fcnt_reg;
        scnt_next      = scnt_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        start_run      = 1'b0;
        finish         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.operation)
                        OP_ADD_FIRST:
                        begin
                            if (fcnt_reg < CNT_W'(MAX_VERTICES))
                            begin
                                fcnt_next = fcnt_reg + CNT_W'(1);
                            end
                        end
                        OP_ADD_SECOND:
                        begin
                            if (scnt_reg < CNT_W'(MAX_VERTICES))
                            begin
                                scnt_next = scnt_reg + CNT_W'(1);
                            end
                        end
                        OP_TEST:
                        begin
                            if ((fcnt_reg == '0) || (scnt_reg == '0))
                            begin
                                out_valid_next = 1'b1;
                                out_data_next  = '0;
                                fcnt_next      = '0;
                                scnt_next      = '0;
                            end
                            else
                            begin
                                start_run = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (start_run)
                begin
                    state_next = ST_RUN;
                    i_next     = '0;
                    j_next     = '0;
                end
            end
            ST_RUN, ST_DRAIN:
            begin
                if (state_reg == ST_RUN)
                begin
                    if (wrap_j)
                    begin
                        j_next = '0;
                        if (wrap_i)
                        begin
                            state_next = ST_DRAIN;
                        end
                        else
                        begin
                            i_next = i_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        j_next = j_reg + IDX_W'(1);
                    end
                end
                if (res_vld && (res_hit || res_tag[TAG_W-1]))
                begin
                    finish         = 1'b1;
                    state_next     = ST_IDLE;
                    fcnt_next      = '0;
                    scnt_next      = '0;
                    out_valid_next = 1'b1;
                    out_data_next  = '{overlap:     res_hit,
                                       edge_first:  res_hit ? EDGE_W'(res_i) : '0,
                                       edge_second: res_hit ? EDGE_W'(res_j) : '0};
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign flush = finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fcnt_reg      <= '0;
            scnt_reg      <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fcnt_reg      <= fcnt_next;
            scnt_reg      <= scnt_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ hdl/pge_checker.sv @@
// ----------------------------------------------------------------------------
// Polygon edge overlap checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pge_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire pge_pkg::pge_in_t  in_data,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire pge_pkg::pge_out_t out_data
);
    import pge_pkg::*;

    // A stalled result holds until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // A miss reports zero edge indices.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.overlap |-> (out_data.edge_first == '0) &&
                                           (out_data.edge_second == '0))
        else $error("miss with nonzero edge index");

    // A test is only taken when the result register is free.
    a_test_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.operation == OP_TEST) |-> !out_valid)
        else $error("test taken over a pending result");

    // A load never produces a result by itself.
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.operation != OP_TEST) && !out_valid
        && $past(in_ready) |=> !out_valid)
        else $error("result after a load");

endmodule

bind polygon_edge_overlap_test pge_checker u_pge_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

@@ tb/tb_polygon_edge_overlap_test.sv @@
// ----------------------------------------------------------------------------
// Polygon edge overlap testbench
// Loads vertex pairs, runs overlap tests and checks every answer against an
// exact integer predictor, under varied idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_polygon_edge_overlap_test;

    import pge_pkg::*;

    localparam int NVERT = 16;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    pge_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    pge_out_t out_data;

    polygon_edge_overlap_test dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    vertex_t  poly_a [NVERT];
    vertex_t  poly_b [NVERT];
    int       count_a;
    int       count_b;
    pge_out_t pending_answers [$];
    int       mismatches;
    int       send_idle_pct;
    int       recv_idle_pct;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic edges_cross(vertex_t a, vertex_t b, vertex_t c, vertex_t d);
        longint abx, aby, cdx, cdy, acx, acy, den, na, nb;
        abx = longint'(b.x) - a.x;
        aby = longint'(b.y) - a.y;
        cdx = longint'(d.x) - c.x;
        cdy = longint'(d.y) - c.y;
        acx = longint'(a.x) - c.x;
        acy = longint'(a.y) - c.y;
        den = cdy * abx - cdx * aby;
        na  = cdx * acy - cdy * acx;
        nb  = abx * acy - aby * acx;
        if (den == 0)
            return 1'b0;
        if (den > 0)
            return na >= 0 && na <= den && nb >= 0 && nb <= den;
        return na <= 0 && na >= den && nb <= 0 && nb >= den;
    endfunction

    // Mirrors the block's state for one accepted transfer.
    task automatic predict_overlap(pge_in_t item);
        vertex_t  v;
        pge_out_t ans;
        logic     hit;
        v.x = item.x_coord;
        v.y = item.y_coord;
        hit = 1'b0;
        ans = '0;
        if (item.operation == OP_ADD_FIRST)
        begin
            if (count_a < NVERT)
            begin
                poly_a[count_a] = v;
                count_a++;
            end
        end
        else if (item.operation == OP_ADD_SECOND)
        begin
            if (count_b < NVERT)
            begin
                poly_b[count_b] = v;
                count_b++;
            end
        end
        else if (item.operation == OP_TEST)
        begin
            for (int i = 0; i < count_a && !hit; i++)
            begin
                for (int j = 0; j < count_b && !hit; j++)
                begin
                    if (edges_cross(poly_a[i], poly_a[(i + 1) % count_a],
                                    poly_b[j], poly_b[(j + 1) % count_b]))
                    begin
                        hit = 1'b1;
                        ans.overlap = 1'b1;
                        ans.edge_first = i[EDGE_W-1:0];
                        ans.edge_second = j[EDGE_W-1:0];
                    end
                end
            end
            pending_answers.push_back(ans);
            count_a = 0;
            count_b = 0;
        end
    endtask

    // Valid stays high from one transfer into the next unless the sender idles.
    task automatic send_item(logic [1:0] op, logic signed [15:0] x, logic signed [15:0] y);
        pge_in_t item;
        item.operation = op;
        item.x_coord = x;
        item.y_coord = y;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_overlap(item);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transfer: %p", out_data);
            end
            else
            begin
                pge_out_t want;
                want = pending_answers.pop_front();
                if (out_data.overlap !== want.overlap
                    || out_data.edge_first !== want.edge_first
                    || out_data.edge_second !== want.edge_second)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result mismatch: expected %p, got %p", want, out_data);
                end
            end
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic logic signed [15:0] rand_coord(int span);
        if (span == 0)
            return 16'($urandom);
        return 16'($urandom_range(2 * span) - span);
    endfunction

    task automatic test_directed();
        // A square crossing a triangle; extreme coordinates.
        send_item(OP_ADD_FIRST, 0, 0);
        send_item(OP_ADD_FIRST, 10, 0);
        send_item(OP_ADD_FIRST, 10, 10);
        send_item(OP_ADD_FIRST, 0, 10);
        send_item(OP_ADD_SECOND, 5, 5);
        send_item(OP_ADD_SECOND, 15, 5);
        send_item(OP_ADD_SECOND, 15, 15);
        send_item(OP_TEST, -1, -1);
        send_item(OP_ADD_FIRST, -32768, -32768);
        send_item(OP_ADD_FIRST, 32767, 32767);
        send_item(OP_ADD_SECOND, -32768, 32767);
        send_item(OP_ADD_SECOND, 32767, -32768);
        send_item(OP_TEST, 0, 0);
        // Parallel edges, a one-vertex polygon, and an empty polygon.
        send_item(OP_ADD_FIRST, 0, 0);
        send_item(OP_ADD_FIRST, 10, 0);
        send_item(OP_ADD_SECOND, 0, 0);
        send_item(OP_ADD_SECOND, 20, 0);
        send_item(OP_TEST, 0, 0);
        send_item(OP_ADD_FIRST, 3, 3);
        send_item(OP_ADD_SECOND, 3, 3);
        send_item(OP_TEST, 0, 0);
        send_item(OP_ADD_SECOND, 1, 1);
        send_item(OP_TEST, 0, 0);
        send_item(2'd3, 16'h7fff, 16'h8000);
        send_item(OP_TEST, 0, 0);
    endtask

    // Mostly whole polygons, some overfilling the stores, some noise.
    task automatic test_random(int n_items);
        int sent;
        int na, nb, span;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_item(2'($urandom), rand_coord(0), rand_coord(0));
                sent++;
            end
            else
            begin
                na = ($urandom_range(9) == 0) ? 18 : $urandom_range(0, 6);
                nb = ($urandom_range(9) == 0) ? 18 : $urandom_range(0, 6);
                span = ($urandom_range(3) == 0) ? 0 : $urandom_range(2, 40);
                for (int i = 0; i < na; i++)
                    send_item(OP_ADD_FIRST, rand_coord(span), rand_coord(span));
                for (int i = 0; i < nb; i++)
                    send_item(OP_ADD_SECOND, rand_coord(span), rand_coord(span));
                send_item(OP_TEST, rand_coord(0), rand_coord(0));
                sent += na + nb + 1;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        count_a = 0;
        count_b = 0;
        mismatches = 0;
        send_idle_pct = 8;
        recv_idle_pct = 52;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(400);
        send_idle_pct = 52;
        recv_idle_pct = 8;
        test_random(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(330);
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

@@ polygon_edge_overlap_test.f @@
hdl/pge_pkg.sv
hdl/pge_cell.sv
hdl/pge_pair_unit.sv
hdl/polygon_edge_overlap_test.sv
hdl/pge_checker.sv
tb/tb_polygon_edge_overlap_test.sv
